// File: hdl/adll_pkg.sv
// Types and constants shared by the array doubly linked list block.
// No dependencies; both interfaces and the list module import this package.
package adll_pkg;

  localparam int unsigned NODE_W  = 10;
  localparam int unsigned VALUE_W = 32;

  localparam logic [NODE_W-1:0] HEAD_NODE = 10'd0;
  localparam logic [NODE_W-1:0] TAIL_NODE = 10'd1;

  typedef enum logic [1:0] {
    OP_INS_AFTER  = 2'd0,
    OP_INS_BEFORE = 2'd1,
    OP_REMOVE     = 2'd2,
    OP_READ       = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_FULL = 2'd1,
    ST_BAD  = 2'd2
  } status_e;

  typedef struct packed {
    logic [1:0]                operation;
    logic [NODE_W-1:0]         node;
    logic signed [VALUE_W-1:0] value;
  } req_t;

  typedef struct packed {
    logic [1:0]                status;
    logic [NODE_W-1:0]         new_node;
    logic signed [VALUE_W-1:0] node_value;
    logic [NODE_W-1:0]         left_link;
    logic [NODE_W-1:0]         right_link;
  } rsp_t;

endpackage

// File: hdl/adll_req_if.sv
// Request channel: valid/ready handshake carrying one list request.
// Depends on adll_pkg for the payload type.
interface adll_req_if;
  import adll_pkg::*;

  logic valid;
  logic ready;
  req_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// File: hdl/adll_rsp_if.sv
// Response channel: valid/ready handshake carrying one request result.
// Depends on adll_pkg for the payload type.
interface adll_rsp_if;
  import adll_pkg::*;

  logic valid;
  logic ready;
  rsp_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// File: hdl/array_doubly_linked_list.sv
// Doubly linked list in a fixed node pool, held in four RAMs (value, left, right, removed).
// Depends on adll_pkg, adll_req_if, adll_rsp_if and adll_ram.
//
//   channel  dir  transfer carries
//   req_i    in   operation, node, value
//   rsp_o    out  status, new_node, node_value, left_link, right_link
//
// A request is read from the RAMs in the cycle it transfers; read, remove and a
// rejected insert finish in the lookup state, a successful insert takes a second
// write state for the neighbor links, set by the single write port of each link
// RAM. A new request is taken only once the last one has finished.
// After reset the init state writes the sentinel links before the first transfer.
// A full output register holds the finishing state until rsp_o takes its transfer.
module array_doubly_linked_list #(
  parameter int unsigned CAPACITY = 1024
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  adll_req_if.sink   req_i,
  adll_rsp_if.source rsp_o
);
  import adll_pkg::*;

  localparam int unsigned AW  = $clog2(CAPACITY);
  localparam int unsigned NFW = $clog2(CAPACITY + 1);
  localparam int unsigned CW  = (NFW > NODE_W) ? NFW : NODE_W;

  localparam logic [1:0] S_INIT = 2'd0;
  localparam logic [1:0] S_IDLE = 2'd1;
  localparam logic [1:0] S_LOOK = 2'd2;
  localparam logic [1:0] S_LINK = 2'd3;

  logic [1:0]         state_q, state_d;
  logic [NFW-1:0]     nf_q, nf_d;
  logic [1:0]         op_q;
  logic [NODE_W-1:0]  node_q;
  logic [VALUE_W-1:0] value_q;
  logic [AW-1:0]      link_q, link_d;
  logic               out_v_q, out_v_d;
  rsp_t               rsp_q, rsp_d;

  logic               rd_en;
  logic [AW-1:0]      rd_addr;
  logic [VALUE_W-1:0] rd_value;
  logic [AW-1:0]      rd_left, rd_right;
  logic               rd_dead;

  logic               val_we, left_we, right_we, dead_we;
  logic [AW-1:0]      val_wa, left_wa, right_wa, dead_wa;
  logic [AW-1:0]      left_wd, right_wd;
  logic               dead_wd;

  logic               slot_free, live, is_sent, ins_bad, full, ins_go;
  logic [AW-1:0]      a_idx, n_idx;
  rsp_t               res;

  assign req_i.ready   = (state_q == S_IDLE);
  assign rd_en         = req_i.valid && req_i.ready;
  assign rd_addr       = AW'(req_i.payload.node);
  assign rsp_o.valid   = out_v_q;
  assign rsp_o.payload = rsp_q;
  assign slot_free     = !out_v_q || rsp_o.ready;

  assign a_idx   = AW'(node_q);
  assign n_idx   = AW'(nf_q);
  assign is_sent = (node_q == HEAD_NODE) || (node_q == TAIL_NODE);
  assign live    = (CW'(node_q) < CW'(nf_q)) && (is_sent || !rd_dead);
  assign ins_bad = ((op_q == OP_INS_AFTER) && (node_q == TAIL_NODE)) ||
                   ((op_q == OP_INS_BEFORE) && (node_q == HEAD_NODE));
  assign full    = (nf_q == NFW'(CAPACITY));
  assign ins_go  = live && ((op_q == OP_INS_AFTER) || (op_q == OP_INS_BEFORE)) &&
                   !ins_bad && !full;

  always_comb begin
    res = '0;
    if (!live) begin
      res.status = ST_BAD;
    end else begin
      unique case (op_q)
        OP_READ: begin
          res.status     = ST_OK;
          res.node_value = is_sent ? '0 : rd_value;
          res.left_link  = (node_q == HEAD_NODE) ? '0 : NODE_W'(rd_left);
          res.right_link = (node_q == TAIL_NODE) ? '0 : NODE_W'(rd_right);
        end
        OP_REMOVE: begin
          res.status = is_sent ? ST_BAD : ST_OK;
        end
        default: begin
          res.status = ins_bad ? ST_BAD : (full ? ST_FULL : ST_OK);
        end
      endcase
    end
  end

  always_comb begin
    state_d  = state_q;
    nf_d     = nf_q;
    link_d   = link_q;
    out_v_d  = out_v_q && !rsp_o.ready;
    rsp_d    = rsp_q;
    val_we   = 1'b0;
    left_we  = 1'b0;
    right_we = 1'b0;
    dead_we  = 1'b0;
    val_wa   = n_idx;
    left_wa  = n_idx;
    right_wa = n_idx;
    dead_wa  = n_idx;
    left_wd  = '0;
    right_wd = '0;
    dead_wd  = 1'b0;
    unique case (state_q)
      S_INIT: begin
        right_we = 1'b1;
        right_wa = AW'(HEAD_NODE);
        right_wd = AW'(TAIL_NODE);
        left_we  = 1'b1;
        left_wa  = AW'(TAIL_NODE);
        left_wd  = AW'(HEAD_NODE);
        state_d  = S_IDLE;
      end
      S_IDLE: begin
        if (rd_en) begin
          state_d = S_LOOK;
        end
      end
      S_LOOK: begin
        if (ins_go) begin
          val_we   = 1'b1;
          dead_we  = 1'b1;
          left_we  = 1'b1;
          right_we = 1'b1;
          if (op_q == OP_INS_AFTER) begin
            left_wd  = a_idx;
            right_wd = rd_right;
            link_d   = rd_right;
          end else begin
            left_wd  = rd_left;
            right_wd = a_idx;
            link_d   = rd_left;
          end
          state_d = S_LINK;
        end else if (slot_free) begin
          if (live && (op_q == OP_REMOVE) && !is_sent) begin
            right_we = 1'b1;
            right_wa = rd_left;
            right_wd = rd_right;
            left_we  = 1'b1;
            left_wa  = rd_right;
            left_wd  = rd_left;
            dead_we  = 1'b1;
            dead_wa  = a_idx;
            dead_wd  = 1'b1;
          end
          out_v_d = 1'b1;
          rsp_d   = res;
          state_d = S_IDLE;
        end
      end
      S_LINK: begin
        if (slot_free) begin
          left_we  = 1'b1;
          right_we = 1'b1;
          left_wd  = n_idx;
          right_wd = n_idx;
          if (op_q == OP_INS_AFTER) begin
            left_wa  = link_q;
            right_wa = a_idx;
          end else begin
            left_wa  = a_idx;
            right_wa = link_q;
          end
          out_v_d        = 1'b1;
          rsp_d          = '0;
          rsp_d.status   = ST_OK;
          rsp_d.new_node = NODE_W'(nf_q);
          nf_d           = nf_q + NFW'(1);
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_INIT;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_INIT;
      nf_q    <= NFW'(2);
      out_v_q <= 1'b0;
    end else begin
      state_q <= state_d;
      nf_q    <= nf_d;
      out_v_q <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      op_q    <= req_i.payload.operation;
      node_q  <= req_i.payload.node;
      value_q <= req_i.payload.value;
    end
    link_q <= link_d;
    rsp_q  <= rsp_d;
  end

  adll_ram #(.WIDTH(VALUE_W), .DEPTH(CAPACITY)) u_value_ram (
    .clk_i  (clk_i),
    .we_i   (val_we),
    .waddr_i(val_wa),
    .wdata_i(value_q),
    .re_i   (rd_en),
    .raddr_i(rd_addr),
    .rdata_o(rd_value)
  );

  adll_ram #(.WIDTH(AW), .DEPTH(CAPACITY)) u_left_ram (
    .clk_i  (clk_i),
    .we_i   (left_we),
    .waddr_i(left_wa),
    .wdata_i(left_wd),
    .re_i   (rd_en),
    .raddr_i(rd_addr),
    .rdata_o(rd_left)
  );

  adll_ram #(.WIDTH(AW), .DEPTH(CAPACITY)) u_right_ram (
    .clk_i  (clk_i),
    .we_i   (right_we),
    .waddr_i(right_wa),
    .wdata_i(right_wd),
    .re_i   (rd_en),
    .raddr_i(rd_addr),
    .rdata_o(rd_right)
  );

  adll_ram #(.WIDTH(1), .DEPTH(CAPACITY)) u_dead_ram (
    .clk_i  (clk_i),
    .we_i   (dead_we),
    .waddr_i(dead_wa),
    .wdata_i(dead_wd),
    .re_i   (rd_en),
    .raddr_i(rd_addr),
    .rdata_o(rd_dead)
  );
endmodule

// File: hdl/adll_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module adll_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end
endmodule
